### hdl/mrc_pkg.sv
// Shared constants, register codes and transaction types for the mixed-radix
// index converter. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mrc_pkg;

  // Fixed geometry: four digit positions of four bits, a 16-bit flat index
  localparam int NUM_POS        = 4;
  localparam int DIGIT_BITS     = 4;
  localparam int MAX_DIGITS_DEF = 4;
  localparam int IDX_BITS       = 16;
  localparam int COUNT_BITS     = 3;
  localparam int RADIX_BITS     = DIGIT_BITS + 1;

  // Weight of position 0 is the product of the three radices after it
  localparam int W_BITS    = DIGIT_BITS * (NUM_POS - 1) + 1;
  localparam int PAIR_BITS = 2 * DIGIT_BITS + 1;
  localparam int TERM_BITS = DIGIT_BITS + W_BITS;
  localparam int SUM_BITS  = TERM_BITS + $clog2(NUM_POS);

  // Pipeline depths
  localparam int DIV_STEPS = IDX_BITS;
  localparam int IN_STAGES = 3;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = RADIX_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIGIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_ZERO  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_ONE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_TWO   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_THREE = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd2;

  // Operation codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [RADIX_BITS-1:0] RADIX_ONE = RADIX_BITS'(1);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(1 << DIGIT_BITS);
  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = '1;
  localparam logic [IDX_BITS-1:0]   INDEX_MAX = '1;

  typedef logic [NUM_POS-1:0][RADIX_BITS-1:0] radix_vec_t;
  typedef logic [NUM_POS-1:0][DIGIT_BITS-1:0] digit_vec_t;

  // Settled scaling derived from the configuration registers
  typedef struct packed {
    logic [NUM_POS-1:0][W_BITS-1:0] weight;
    radix_vec_t                     radix;
    logic [COUNT_BITS-1:0]          used;
  } mrc_scale_t;

  // Control travelling alongside each transaction
  typedef struct packed {
    logic valid;
    logic func;
  } mrc_ctl_t;

  // Input payload held in the entry stages
  typedef struct packed {
    digit_vec_t            digit;
    logic [IDX_BITS-1:0]   index;
  } mrc_item_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [IDX_BITS-1:0]  quot;
    logic [TERM_BITS-1:0] term;
    logic                 oor;
  } mrc_lane_res_t;

endpackage

### hdl/mrc_weights.sv
// Scaling unit: clamps radices, masks unused positions and forms position
// weights in two registered product levels. Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_weights import mrc_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic [COUNT_BITS-1:0] digit_count,
  input  radix_vec_t            radix,
  output mrc_scale_t            scale
);

  localparam int CAP_RAW = (MAX_DIGITS < NUM_POS) ? MAX_DIGITS : NUM_POS;
  localparam logic [COUNT_BITS-1:0] CAP = COUNT_BITS'(CAP_RAW);
  localparam int TRIPLE_BITS = RADIX_BITS + PAIR_BITS;

  logic [COUNT_BITS-1:0]  used_c;
  radix_vec_t             u_c;
  radix_vec_t             u1_q;
  logic [COUNT_BITS-1:0]  used1_q;
  logic [PAIR_BITS-1:0]   pair_q;
  logic [TRIPLE_BITS-1:0] triple_c;

  // Effective count and radices; unused positions weigh as radix one
  always_comb begin
    used_c = (digit_count > CAP) ? CAP : digit_count;
    for (int j = 0; j < NUM_POS; j++) begin
      if (COUNT_BITS'(j) >= used_c) begin
        u_c[j] = RADIX_ONE;
      end else if (radix[j] == '0) begin
        u_c[j] = RADIX_ONE;
      end else if (radix[j] > RADIX_MAX) begin
        u_c[j] = RADIX_MAX;
      end else begin
        u_c[j] = radix[j];
      end
    end
  end

  // Level one: product of the two least significant radices
  always_ff @(posedge clk) begin
    u1_q    <= u_c;
    used1_q <= used_c;
    pair_q  <= PAIR_BITS'(u_c[2]) * PAIR_BITS'(u_c[3]);
  end

  assign triple_c = TRIPLE_BITS'(u1_q[1]) * TRIPLE_BITS'(pair_q);

  // Level two: weights of every position
  always_ff @(posedge clk) begin
    scale.weight[0] <= triple_c[W_BITS-1:0];
    scale.weight[1] <= W_BITS'(pair_q);
    scale.weight[2] <= W_BITS'(u1_q[3]);
    scale.weight[3] <= W_BITS'(1);
    scale.radix     <= u1_q;
    scale.used      <= used1_q;
  end

endmodule

### hdl/mrc_lane.sv
// One digit lane: a restoring quotient pipeline (one bit a stage) dividing the
// flat index by this position's weight, plus the encode term. Uses mrc_pkg.
`timescale 1ns / 1ps

module mrc_lane import mrc_pkg::*; (
  input  logic                  clk,
  input  logic [DIGIT_BITS-1:0] digit,
  input  logic [IDX_BITS-1:0]   index,
  input  logic [W_BITS-1:0]     weight,
  input  logic [RADIX_BITS-1:0] radix,
  input  logic                  used,
  output mrc_lane_res_t         res
);

  localparam int LAST = DIV_STEPS - 1;

  logic [W_BITS-1:0]     rem_q   [DIV_STEPS];
  logic [IDX_BITS-1:0]   work_q  [DIV_STEPS];
  logic [W_BITS-1:0]     rem_n   [DIV_STEPS];
  logic [IDX_BITS-1:0]   work_n  [DIV_STEPS];
  logic [W_BITS-1:0]     src_rem [DIV_STEPS];
  logic [IDX_BITS-1:0]   src_work[DIV_STEPS];
  logic [W_BITS:0]       trial   [DIV_STEPS];
  logic                  ge      [DIV_STEPS];
  logic [DIGIT_BITS-1:0] digit_q [LAST];
  logic [TERM_BITS-1:0]  term_q;
  logic                  oor_q;

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_head
      assign src_rem[k]  = '0;
      assign src_work[k] = index;
    end else begin : g_body
      assign src_rem[k]  = rem_q[k-1];
      assign src_work[k] = work_q[k-1];
    end
    assign trial[k]  = {src_rem[k], src_work[k][IDX_BITS-1]};
    assign ge[k]     = trial[k] >= {1'b0, weight};
    assign rem_n[k]  = ge[k] ? W_BITS'(trial[k] - {1'b0, weight}) : trial[k][W_BITS-1:0];
    assign work_n[k] = {src_work[k][IDX_BITS-2:0], ge[k]};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_q[k]  <= rem_n[k];
      work_q[k] <= work_n[k];
    end
  end

  // Digit rides along; encode term and range check land with the quotient
  always_ff @(posedge clk) begin
    digit_q[0] <= digit;
    for (int k = 1; k < LAST; k++) begin
      digit_q[k] <= digit_q[k-1];
    end
    term_q <= used ? TERM_BITS'(digit_q[LAST-1]) * TERM_BITS'(weight) : '0;
    oor_q  <= used && (RADIX_BITS'(digit_q[LAST-1]) >= radix);
  end

  assign res.quot = work_q[LAST];
  assign res.term = term_q;
  assign res.oor  = oor_q;

endmodule

### hdl/mrc_merge.sv
// Merge stage: sums lane terms for encode, turns lane quotients into digits
// for decode, and registers the result transaction. Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_merge import mrc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  mrc_ctl_t            ctl,
  input  mrc_lane_res_t       res [NUM_POS],
  input  mrc_scale_t          scale,
  output logic                done,
  output logic [IDX_BITS-1:0] flat,
  output digit_vec_t          digit,
  output logic                oor
);

  localparam int CARRY_BITS = 2 * DIGIT_BITS;

  logic [SUM_BITS-1:0]   sum_c;
  logic                  enc_oor_c;
  logic                  dec_oor_c;
  digit_vec_t            digit_c;
  logic [CARRY_BITS-1:0] carry_c [NUM_POS];

  // Encode: add the weighted terms, flag any digit at or above its radix
  always_comb begin
    sum_c     = '0;
    enc_oor_c = 1'b0;
    for (int i = 0; i < NUM_POS; i++) begin
      sum_c     = sum_c + SUM_BITS'(res[i].term);
      enc_oor_c = enc_oor_c | res[i].oor;
    end
  end

  // Decode: digit i = floor(x/w_i) - radix_i * floor(x/w_(i-1)), exact mod 2^DIGIT_BITS
  always_comb begin
    dec_oor_c  = res[0].quot >= IDX_BITS'(scale.radix[0]);
    carry_c[0] = '0;
    if (scale.used == '0) begin
      digit_c[0] = '0;
    end else if (res[0].quot > IDX_BITS'(DIGIT_MAX)) begin
      digit_c[0] = DIGIT_MAX;
    end else begin
      digit_c[0] = res[0].quot[DIGIT_BITS-1:0];
    end
    for (int i = 1; i < NUM_POS; i++) begin
      carry_c[i] = CARRY_BITS'(res[i-1].quot[DIGIT_BITS-1:0]) *
                   CARRY_BITS'(scale.radix[i][DIGIT_BITS-1:0]);
      if (COUNT_BITS'(i) < scale.used) begin
        digit_c[i] = res[i].quot[DIGIT_BITS-1:0] - carry_c[i][DIGIT_BITS-1:0];
      end else begin
        digit_c[i] = '0;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.func == FUNC_ENCODE) begin
      flat  <= (enc_oor_c || (sum_c > SUM_BITS'(INDEX_MAX))) ? INDEX_MAX
                                                           : sum_c[IDX_BITS-1:0];
      digit <= '0;
      oor   <= enc_oor_c;
    end else begin
      flat  <= '0;
      digit <= digit_c;
      oor   <= dec_oor_c;
    end
  end

endmodule

### hdl/mixed_radix_index_convert.sv
// Mixed-radix index converter, top level: configuration registers, entry
// stages, digit lanes and merge. Depends on mrc_pkg, mrc_weights, mrc_lane, mrc_merge.
`timescale 1ns / 1ps
//
// Usage
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. func selects encode (digits to flat index) or decode (flat
//   index to digits). busy is high only while rst is held.
//   Result channel: done is high for exactly one cycle with flat_index_out,
//   the four digit outputs and out_of_range; the result is taken at the edge
//   that ends that cycle. The receiver cannot stall, so nothing is held back.
//   Depth: a transaction passes three entry stages, sixteen quotient steps and
//   one merge register, a depth set by the bit-per-stage quotient pipeline in
//   each lane.
//   Throughput: one transaction per cycle, back to back, in order.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   (0 digit_count, 1 to 4 radix_zero to radix_three); other indexes are
//   ignored. Writes made while the block is idle apply to transactions
//   started at or after the write edge.
//   Reset: synchronous; clears in-flight transactions and restores a count of
//   four with every radix at two.

module mixed_radix_index_convert import mrc_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic [DIGIT_BITS-1:0]    digit_in_zero,
  input  logic [DIGIT_BITS-1:0]    digit_in_one,
  input  logic [DIGIT_BITS-1:0]    digit_in_two,
  input  logic [DIGIT_BITS-1:0]    digit_in_three,
  input  logic [IDX_BITS-1:0]      flat_index_in,
  output logic                     done,
  output logic [IDX_BITS-1:0]      flat_index_out,
  output logic [DIGIT_BITS-1:0]    digit_out_zero,
  output logic [DIGIT_BITS-1:0]    digit_out_one,
  output logic [DIGIT_BITS-1:0]    digit_out_two,
  output logic [DIGIT_BITS-1:0]    digit_out_three,
  output logic                     out_of_range
);

  localparam int LANES     = (MAX_DIGITS < NUM_POS) ? MAX_DIGITS : NUM_POS;
  localparam int CTL_DEPTH = IN_STAGES + DIV_STEPS;
  // Sampled strobe trails the sampled accept by the control depth plus the merge register
  localparam int LATENCY   = CTL_DEPTH + 1;

  logic                  accept;
  logic [COUNT_BITS-1:0] digit_count;
  radix_vec_t            radix;
  mrc_scale_t            scale;
  mrc_ctl_t              ctl_q  [CTL_DEPTH];
  mrc_item_t             item_q [IN_STAGES];
  mrc_lane_res_t         lane_res [NUM_POS];
  logic [NUM_POS-1:0]    lane_used;
  digit_vec_t            digit_res;

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_RESET;
      for (int j = 0; j < NUM_POS; j++) begin
        radix[j] <= RADIX_RESET;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIGIT_COUNT: digit_count <= cfg_data[COUNT_BITS-1:0];
        REG_RADIX_ZERO:  radix[0]    <= cfg_data;
        REG_RADIX_ONE:   radix[1]    <= cfg_data;
        REG_RADIX_TWO:   radix[2]    <= cfg_data;
        REG_RADIX_THREE: radix[3]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mrc_weights #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_weights (
    .clk         (clk),
    .digit_count (digit_count),
    .radix       (radix),
    .scale       (scale)
  );

  // Transaction control pipeline, aligned with the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CTL_DEPTH; k++) begin
        ctl_q[k] <= '0;
      end
    end else begin
      ctl_q[0].valid <= accept;
      ctl_q[0].func  <= func;
      for (int k = 1; k < CTL_DEPTH; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // Entry stages; the scaling unit has settled by the time they drain
  always_ff @(posedge clk) begin
    item_q[0].digit[0] <= digit_in_zero;
    item_q[0].digit[1] <= digit_in_one;
    item_q[0].digit[2] <= digit_in_two;
    item_q[0].digit[3] <= digit_in_three;
    item_q[0].index    <= flat_index_in;
    for (int k = 1; k < IN_STAGES; k++) begin
      item_q[k] <= item_q[k-1];
    end
  end

  // Digit lanes; positions beyond the lane count stay silent
  for (genvar i = 0; i < NUM_POS; i++) begin : g_lane
    assign lane_used[i] = COUNT_BITS'(i) < scale.used;
    if (i < LANES) begin : g_on
      mrc_lane u_lane (
        .clk    (clk),
        .digit  (item_q[IN_STAGES-1].digit[i]),
        .index  (item_q[IN_STAGES-1].index),
        .weight (scale.weight[i]),
        .radix  (scale.radix[i]),
        .used   (lane_used[i]),
        .res    (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
  end

  mrc_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl_q[CTL_DEPTH-1]),
    .res   (lane_res),
    .scale (scale),
    .done  (done),
    .flat  (flat_index_out),
    .digit (digit_res),
    .oor   (out_of_range)
  );

  assign digit_out_zero  = digit_res[0];
  assign digit_out_one   = digit_res[1];
  assign digit_out_two   = digit_res[2];
  assign digit_out_three = digit_res[3];

`ifndef SYNTHESIS
  // Every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted transaction did not complete on time");

  // No result without a transaction accepted one latency earlier
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transaction");

  // Non-zero digits only come from decode, which leaves the flat index at zero
  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    (done && (digit_out_zero != '0 || digit_out_one != '0 ||
              digit_out_two != '0 || digit_out_three != '0))
      |-> (flat_index_out == '0))
    else $error("digits and flat index both non-zero in one result");
`endif

endmodule
